@@ rtl/lzw_pkg.sv @@
// Shared types and constants, including the hash multiplier, for the LZW encoder.
package lzw_pkg;

	localparam int CodeCount   = 65536;
	localparam int BucketCount = 4096;
	localparam int FirstFree   = 256;
	localparam int Mix         = 337;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} lzw_in_t;

	typedef struct packed {
		logic [15:0] code_out;
		logic        final_code;
	} lzw_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take_item;     // latch input word
		logic clr_start;     // begin bucket clearing pass
		logic clr_step;      // clear one bucket
		logic hash_rd;       // read bucket head
		logic chain_rd;      // read entry at current code
		logic chain_next;    // follow link from entry
		logic add_entry;     // write new entry and bucket head
		logic set_hit;       // match becomes found code
		logic set_miss;      // match restarts from byte
		logic set_first;     // first byte of stream
		logic out_miss;      // load miss code into output
		logic out_flush;     // load flush code into output
		logic flush_reset;   // drop match, empty dictionary
	} lzw_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic match_valid;
		logic last;
		logic clr_done;
		logic code_valid;    // current chain code is below code count
		logic pair_equal;    // entry matches (prefix, byte)
		logic out_full;      // output register holds a word
	} lzw_sts_t;

endpackage

@@ rtl/lzw_datapath.sv @@
// Datapath of the LZW encoder: match state, dictionary memories, output register.
module lzw_datapath
	import lzw_pkg::*;
#(
	parameter int CODE_COUNT   = CodeCount,
	parameter int BUCKET_COUNT = BucketCount
) (
	input  logic     clk,
	input  logic     arst_n,
	input  lzw_in_t  in_data,
	input  lzw_cmd_t cmd,
	output lzw_sts_t sts,
	output lzw_out_t out_data,
	output logic     out_valid,
	input  logic     out_ready
);

	localparam int CW = $clog2(CODE_COUNT);
	localparam int BW = $clog2(BUCKET_COUNT);
	localparam logic [16:0] NoLink = 17'h1FFFF;

	// Dictionary stores
	logic [15:0] prefix_mem [CODE_COUNT];
	logic [7:0]  byte_mem   [CODE_COUNT];
	logic [16:0] link_mem   [CODE_COUNT];
	logic [16:0] head_mem   [BUCKET_COUNT];

	logic [15:0] match_q;
	logic        match_valid_q;
	logic [16:0] free_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [BW-1:0] bucket_q;
	logic [BW:0]   clr_q;
	logic [16:0] code_q;
	logic        code_src_q;    // 1: code from head read, 0: from link read
	logic [16:0] head_rd_q;
	logic [15:0] ent_prefix_q;
	logic [7:0]  ent_byte_q;
	logic [16:0] ent_link_q;
	logic [16:0] cur_code;
	lzw_out_t    out_q;
	logic        out_valid_q;
	logic [31:0] hash_prod;

	// Hash of (match, byte) over the bucket count, a power of two
	assign hash_prod = 32'(match_q) * 32'(Mix) + 32'(in_data.in_byte);

	assign cur_code = code_src_q ? head_rd_q : code_q;

	// Latch item and bucket index
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			byte_q   <= in_data.in_byte;
			last_q   <= in_data.end_of_stream;
			bucket_q <= hash_prod[BW-1:0];
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !clr_q[BW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Bucket head memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_step && !clr_q[BW]) begin
			head_mem[clr_q[BW-1:0]] <= NoLink;
		end else if (cmd.add_entry && free_q < 17'(CODE_COUNT)) begin
			head_mem[bucket_q] <= free_q;
		end
		if (cmd.hash_rd) begin
			head_rd_q <= head_mem[bucket_q];
		end
	end

	// Per-code entry memories; the new link is the head read for this word
	always_ff @(posedge clk) begin
		if (cmd.add_entry && free_q < 17'(CODE_COUNT)) begin
			prefix_mem[free_q[CW-1:0]] <= match_q;
			byte_mem[free_q[CW-1:0]]   <= byte_q;
			link_mem[free_q[CW-1:0]]   <= head_rd_q;
		end
		if (cmd.chain_rd) begin
			ent_prefix_q <= prefix_mem[cur_code[CW-1:0]];
			ent_byte_q   <= byte_mem[cur_code[CW-1:0]];
			ent_link_q   <= link_mem[cur_code[CW-1:0]];
		end
	end

	// Track chain position
	always_ff @(posedge clk) begin
		if (cmd.hash_rd) begin
			code_src_q <= 1'b1;
		end else if (cmd.chain_rd) begin
			code_q     <= cur_code;
			code_src_q <= 1'b0;
		end else if (cmd.chain_next) begin
			code_q     <= ent_link_q;
		end
	end

	// Match state and free code counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q       <= '0;
			match_valid_q <= 1'b0;
			free_q        <= 17'(FirstFree);
		end else begin
			if (cmd.set_first) begin
				match_q       <= 16'(byte_q);
				match_valid_q <= 1'b1;
			end else if (cmd.set_hit) begin
				match_q <= code_q[15:0];
			end else if (cmd.set_miss) begin
				match_q <= 16'(byte_q);
			end
			if (cmd.add_entry && free_q < 17'(CODE_COUNT)) begin
				free_q <= free_q + 1'b1;
			end
			if (cmd.flush_reset) begin
				match_q       <= '0;
				match_valid_q <= 1'b0;
				free_q        <= 17'(FirstFree);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_miss || cmd.out_flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_miss) begin
			out_q.code_out   <= match_q;
			out_q.final_code <= 1'b0;
		end else if (cmd.out_flush) begin
			out_q.code_out   <= match_q;
			out_q.final_code <= 1'b1;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	assign sts.match_valid = match_valid_q;
	assign sts.last        = last_q;
	assign sts.clr_done    = clr_q[BW];
	assign sts.code_valid  = code_q < 17'(CODE_COUNT);
	assign sts.pair_equal  = (ent_prefix_q == match_q) && (ent_byte_q == byte_q);
	assign sts.out_full    = out_valid_q && !out_ready;

endmodule

@@ rtl/lzw_control.sv @@
// Controller state machine of the LZW encoder.
module lzw_control
	import lzw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lzw_sts_t sts,
	output lzw_cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_HEAD  = 10'b0000000100,
		ST_LOAD  = 10'b0000001000,
		ST_READ  = 10'b0000010000,
		ST_CMP   = 10'b0000100000,
		ST_MISS  = 10'b0001000000,
		ST_LAST  = 10'b0010000000,
		ST_FLUSH = 10'b0100000000,
		ST_HOLD  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (!sts.match_valid) begin
					cmd.set_first = 1'b1;
					state_d       = ST_LAST;
				end else begin
					cmd.hash_rd = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			// Load the head or the followed link into the chain code and read its entry
			ST_LOAD: begin
				cmd.chain_rd = 1'b1;
				state_d      = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (!sts.code_valid) begin
					state_d = ST_MISS;
				end else if (sts.pair_equal) begin
					cmd.set_hit = 1'b1;
					state_d     = ST_LAST;
				end else begin
					cmd.chain_next = 1'b1;
					state_d        = ST_LOAD;
				end
			end
			ST_MISS: begin
				if (!sts.out_full) begin
					cmd.add_entry = 1'b1;
					cmd.out_miss  = 1'b1;
					cmd.set_miss  = 1'b1;
					state_d       = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = sts.last ? ST_FLUSH : ST_IDLE;
			end
			ST_FLUSH: begin
				if (!sts.out_full) begin
					cmd.out_flush   = 1'b1;
					cmd.flush_reset = 1'b1;
					cmd.clr_start   = 1'b1;
					state_d         = ST_HOLD;
				end
			end
			ST_HOLD: begin
				state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/lzw_encoder_16bit.sv @@
// Top level of the 16-bit LZW encoder.
//
//   port group   dir  handshake                  payload
//   in_*         in   in_valid / in_ready        lzw_in_t  (in_byte, end_of_stream)
//   out_*        out  out_valid / out_ready      lzw_out_t (code_out, final_code)
//
// A byte takes a bucket head read, then an entry read per chain entry walked until a
// hit or the chain end; a miss also emits the match code and, while codes are free,
// writes a new entry; the first byte of a stream only starts the match. The chain
// walk through the entry memory read port sets the time per byte. After reset and
// each flush the bucket heads are cleared one per cycle, while no byte is accepted.
// A held output word stalls the controller only when a new code must be emitted.
module lzw_encoder_16bit
	import lzw_pkg::*;
#(
	parameter int CODE_COUNT   = CodeCount,
	parameter int BUCKET_COUNT = BucketCount
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lzw_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output lzw_out_t out_data
);

	lzw_cmd_t cmd;
	lzw_sts_t sts;

	lzw_control u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzw_datapath #(
		.CODE_COUNT   (CODE_COUNT),
		.BUCKET_COUNT (BUCKET_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

@@ bench/lzw_checker.sv @@
// Checker for the LZW encoder: watches both channels, predicts codes and compares them.
`timescale 1ns / 1ps
module lzw_checker
	import lzw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  lzw_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  lzw_out_t out_data,
	output int       fail_count,
	output int       pending_codes
);

	localparam logic [16:0] NoLink = 17'h1FFFF;

	logic [15:0] cur_code;
	logic        cur_valid;
	logic [16:0] free_code;
	logic [15:0] dict_prefix [CodeCount];
	logic [7:0]  dict_byte   [CodeCount];
	logic [16:0] dict_link   [CodeCount];
	logic [16:0] dict_head   [BucketCount];
	lzw_out_t    code_queue [$];

	function automatic int bucket_index(logic [15:0] prefix, logic [7:0] b);
		return (int'(prefix) * Mix + int'(b)) % BucketCount;
	endfunction

	task automatic clear_dictionary();
		foreach (dict_head[i]) dict_head[i] = NoLink;
		free_code = 17'(FirstFree);
	endtask

	function automatic logic [16:0] lookup_pair(logic [15:0] prefix, logic [7:0] b);
		logic [16:0] c;
		c = dict_head[bucket_index(prefix, b)];
		while (c < 17'(CodeCount)) begin
			if (dict_prefix[c[15:0]] == prefix && dict_byte[c[15:0]] == b)
				return c;
			c = dict_link[c[15:0]];
		end
		return NoLink;
	endfunction

	// Advance the encoder state by one byte and queue the codes it emits
	task automatic encode_byte(lzw_in_t w);
		logic [16:0] hit;
		int          bk;
		lzw_out_t    e;
		if (!cur_valid) begin
			cur_code  = {8'd0, w.in_byte};
			cur_valid = 1'b1;
		end else begin
			hit = lookup_pair(cur_code, w.in_byte);
			if (hit != NoLink) begin
				cur_code = hit[15:0];
			end else begin
				if (free_code < 17'(CodeCount)) begin
					bk = bucket_index(cur_code, w.in_byte);
					dict_prefix[free_code[15:0]] = cur_code;
					dict_byte[free_code[15:0]]   = w.in_byte;
					dict_link[free_code[15:0]]   = dict_head[bk];
					dict_head[bk] = free_code;
					free_code++;
				end
				e.code_out   = cur_code;
				e.final_code = 1'b0;
				code_queue.push_back(e);
				cur_code = {8'd0, w.in_byte};
			end
		end
		if (w.end_of_stream) begin
			e.code_out   = cur_code;
			e.final_code = 1'b1;
			code_queue.push_back(e);
			cur_code  = '0;
			cur_valid = 1'b0;
			clear_dictionary();
		end
	endtask

	// Compare each accepted word with the oldest expected code
	always @(posedge clk or negedge arst_n) begin
		lzw_out_t e;
		if (!arst_n) begin
			cur_code  = '0;
			cur_valid = 1'b0;
			clear_dictionary();
			code_queue.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (code_queue.size() == 0) begin
					$display("%0t: unexpected word code=%h final=%b", $time,
						out_data.code_out, out_data.final_code);
					fail_count++;
				end else begin
					e = code_queue.pop_front();
					if (e.code_out !== out_data.code_out ||
					    e.final_code !== out_data.final_code) begin
						$display("%0t: expected code=%h final=%b, got code=%h final=%b",
							$time, e.code_out, e.final_code,
							out_data.code_out, out_data.final_code);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				encode_byte(in_data);
		end
		pending_codes = code_queue.size();
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the LZW encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import lzw_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	lzw_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	lzw_out_t out_data;
	int       fail_count;
	int       pending_codes;
	int       cycle_count;
	bit       hold_off;
	bit       steady_flow;
	bit       gaps_on;

	lzw_encoder_16bit DUT (.*);
	lzw_checker CHK (.*);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2_000_000) begin
			$display("FAIL lzw_encoder_16bit");
			$finish;
		end
	end

	// Stall the output on a pattern of its own, with one long hold-off on demand
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off && !hold_done) begin
				out_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_done = 1'b1;
			end else if (steady_flow) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= (($urandom % 8) < 5);
			end
		end
	end

	// Offer one word and hold it until accepted
	task automatic send_byte(logic [7:0] b, logic eos);
		in_valid <= 1'b1;
		in_data  <= '{in_byte: b, end_of_stream: eos};
		while (!in_ready) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = gaps_on ? $urandom_range(0, 6) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_codes != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		int        sent;
		int        len;
		int        burst;
		logic [7:0] b;
		logic [7:0] alpha;
		in_valid    = 1'b0;
		in_data     = '0;
		hold_off    = 1'b0;
		steady_flow = 1'b0;
		gaps_on     = 1'b1;
		arst_n      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: single-byte stream, extremes, repeats that grow matches
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		for (int i = 0; i < 12; i++) send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_drained();

		// Long receiver hold-off while bytes keep coming
		hold_off = 1'b1;
		for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 3)), i == 39);
		wait_drained();

		// Random streams: mostly small alphabets so matches grow, some full-range noise
		sent = 0;
		while (sent < 600) begin
			len   = $urandom_range(1, 60);
			alpha = ($urandom % 4 == 0) ? 8'hFF : 8'($urandom_range(1, 5));
			gaps_on     = ($urandom % 3 != 0);
			steady_flow = ($urandom % 4 == 0);
			burst = 0;
			for (int i = 0; i < len; i++) begin
				b = (alpha == 8'hFF) ? 8'($urandom) : 8'($urandom_range(0, alpha)) + 8'hC0;
				send_byte(b, i == len - 1);
				if (++burst >= $urandom_range(2, 10)) begin
					idle_gap();
					burst = 0;
				end
			end
			sent += len;
			if ($urandom % 5 == 0) wait_drained();
		end

		wait_drained();
		if (fail_count == 0)
			$display("PASS lzw_encoder_16bit");
		else
			$display("FAIL lzw_encoder_16bit");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lzw_pkg.sv
rtl/lzw_datapath.sv
rtl/lzw_control.sv
rtl/lzw_encoder_16bit.sv
bench/lzw_checker.sv
bench/tb_top.sv
